// ===== rtl/tmep_pkg.sv =====
// Shared types, byte codes and event codes of the terminal mouse escape parser.
`timescale 1ns / 1ps

package tmep_pkg;

   // Field types of the transfers.
   typedef logic [7:0]        byte_type;
   typedef logic signed [8:0] coord_type;
   typedef logic [2:0]        kind_type;
   typedef logic [1:0]        button_type;
   typedef logic [2:0]        mods_type;
   typedef logic [1:0]        motion_type;

   // Configuration port.
   typedef logic [0:0] csr_index_type;
   typedef logic [7:0] csr_data_type;

   localparam csr_index_type CSR_COORD_OFFSET = 1'd0;
   localparam csr_index_type CSR_NO_BUTTON    = 1'd1;

   localparam byte_type   COORD_OFFSET_RESET = 8'd32;
   localparam button_type NO_BUTTON_RESET    = 2'd3;

   // Bytes of the escape sequences.
   localparam byte_type ESC_CHAR     = 8'h1B;
   localparam byte_type BRACKET_CHAR = 8'h5B;
   localparam byte_type MOUSE_CHAR   = 8'h4D;
   localparam byte_type ZERO_CHAR    = 8'h30;
   localparam byte_type ONE_CHAR     = 8'h31;
   localparam byte_type TWO_CHAR     = 8'h32;
   localparam byte_type TILDE_CHAR   = 8'h7E;

   // Event kinds.
   localparam kind_type EV_KEY        = 3'd0;
   localparam kind_type EV_PRESS      = 3'd1;
   localparam kind_type EV_DRAG_BEGIN = 3'd2;
   localparam kind_type EV_DRAG       = 3'd3;
   localparam kind_type EV_HOVER      = 3'd4;
   localparam kind_type EV_RELEASE    = 3'd5;
   localparam kind_type EV_DRAG_END   = 3'd6;
   localparam kind_type EV_SCROLL     = 3'd7;

   // Motion field codes of a mouse report.
   localparam motion_type MOT_STATIC = 2'd0;
   localparam motion_type MOT_MOVING = 2'd1;
   localparam motion_type MOT_SCROLL = 2'd2;

   // Result queue.
   localparam int FIFO_DEPTH   = 4;
   localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
   localparam int FIFO_LEVEL_W = $clog2(FIFO_DEPTH + 1);

   typedef logic [1:0] push_count_type;

   // One result item.
   typedef struct packed {
      kind_type   event_kind;
      logic       error_flag;
      byte_type   key_code;
      button_type button_now;
      mods_type   modifier_bits;
      motion_type motion_now;
      coord_type  pos_x;
      coord_type  pos_y;
      coord_type  press_x;
      coord_type  press_y;
      button_type press_button;
      logic       last_of_run;
   } rsp_type;

   // A decoded mouse report.
   typedef struct packed {
      button_type button;
      mods_type   mods;
      motion_type motion;
      coord_type  x;
      coord_type  y;
   } mouse_report_type;

   // Events found for one report, and the press event after the update.
   typedef struct packed {
      push_count_type count;
      kind_type       kind0;
      kind_type       kind1;
      button_type     press_button;
      coord_type      press_x;
      coord_type      press_y;
   } track_type;

endpackage

// ===== rtl/tmep_channels.sv =====
// Valid/ready channel interfaces for input bytes and result items.
`timescale 1ns / 1ps

interface tmep_req_if;
   logic               valid;
   logic               ready;
   tmep_pkg::byte_type in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface tmep_rsp_if;
   logic                 valid;
   logic                 ready;
   tmep_pkg::kind_type   event_kind;
   logic                 error_flag;
   tmep_pkg::byte_type   key_code;
   tmep_pkg::button_type button_now;
   tmep_pkg::mods_type   modifier_bits;
   tmep_pkg::motion_type motion_now;
   tmep_pkg::coord_type  pos_x;
   tmep_pkg::coord_type  pos_y;
   tmep_pkg::coord_type  press_x;
   tmep_pkg::coord_type  press_y;
   tmep_pkg::button_type press_button;
   logic                 last_of_run;

   modport source (output valid, output event_kind, output error_flag, output key_code,
                   output button_now, output modifier_bits, output motion_now,
                   output pos_x, output pos_y, output press_x, output press_y,
                   output press_button, output last_of_run, input ready);
   modport sink (input valid, input event_kind, input error_flag, input key_code,
                 input button_now, input modifier_bits, input motion_now,
                 input pos_x, input pos_y, input press_x, input press_y,
                 input press_button, input last_of_run, output ready);
endinterface

// ===== rtl/tmep_tracker.sv =====
// Mouse report tracker: compares a report with the previous one and keeps press and drag state.
`timescale 1ns / 1ps

module tmep_tracker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       report_valid,
   input  tmep_pkg::mouse_report_type report,
   input  tmep_pkg::button_type       no_button,
   output tmep_pkg::track_type        track
);
   import tmep_pkg::*;

   button_type prev_button_ff, prev_button_in;
   motion_type prev_motion_ff, prev_motion_in;
   button_type press_button_ff, press_button_in;
   coord_type  press_x_ff, press_x_in;
   coord_type  press_y_ff, press_y_in;
   logic       drag_ff, drag_in;

   logic       prev_held;
   logic       now_held;
   logic       prev_settled;
   logic       is_press;
   logic       is_drag_begin;
   logic       drag_now;
   logic       is_release;
   logic [4:0] cand_valid;
   kind_type   cand_kind [5];

   assign prev_held     = (prev_button_ff != no_button);
   assign now_held      = (report.button != no_button);
   assign prev_settled  = (prev_motion_ff == MOT_STATIC) || (prev_motion_ff == MOT_MOVING);
   assign is_press      = prev_settled && !prev_held && now_held;
   assign is_drag_begin = (prev_motion_ff == MOT_STATIC) && prev_held &&
                          (report.motion == MOT_MOVING) && now_held;
   assign drag_now      = drag_ff || is_drag_begin;
   assign is_release    = prev_settled && prev_held && (report.motion == MOT_STATIC) &&
                          !now_held;

   // Candidate events in the order they are reported; only the first two survive.
   always_comb begin
      cand_valid[0] = is_press;
      cand_kind[0]  = EV_PRESS;
      cand_valid[1] = is_drag_begin;
      cand_kind[1]  = EV_DRAG_BEGIN;
      cand_valid[2] = drag_now || (report.motion == MOT_MOVING);
      cand_kind[2]  = drag_now ? EV_DRAG : EV_HOVER;
      cand_valid[3] = is_release;
      cand_kind[3]  = drag_now ? EV_DRAG_END : EV_RELEASE;
      cand_valid[4] = (report.motion == MOT_SCROLL);
      cand_kind[4]  = EV_SCROLL;
   end

   always_comb begin
      push_count_type n;
      n           = 2'd0;
      track.kind0 = EV_KEY;
      track.kind1 = EV_KEY;
      for (int i = 0; i < 5; i++) begin
         if (cand_valid[i]) begin
            if (n == 2'd0) begin
               track.kind0 = cand_kind[i];
               n           = 2'd1;
            end else if (n == 2'd1) begin
               track.kind1 = cand_kind[i];
               n           = 2'd2;
            end
         end
      end
      track.count        = n;
      track.press_button = press_button_in;
      track.press_x      = press_x_in;
      track.press_y      = press_y_in;
   end

   always_comb begin
      prev_button_in  = prev_button_ff;
      prev_motion_in  = prev_motion_ff;
      press_button_in = press_button_ff;
      press_x_in      = press_x_ff;
      press_y_in      = press_y_ff;
      drag_in         = drag_ff;
      if (report_valid) begin
         prev_button_in = report.button;
         prev_motion_in = report.motion;
         drag_in        = is_release ? 1'b0 : drag_now;
         if (is_press) begin
            press_button_in = report.button;
            press_x_in      = report.x;
            press_y_in      = report.y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_button_ff  <= '0;
         prev_motion_ff  <= MOT_STATIC;
         press_button_ff <= '0;
         press_x_ff      <= '0;
         press_y_ff      <= '0;
         drag_ff         <= 1'b0;
      end else begin
         prev_button_ff  <= prev_button_in;
         prev_motion_ff  <= prev_motion_in;
         press_button_ff <= press_button_in;
         press_x_ff      <= press_x_in;
         press_y_ff      <= press_y_in;
         drag_ff         <= drag_in;
      end
   end

endmodule

// ===== rtl/tmep_parser.sv =====
// Escape sequence state machine that turns one byte into up to two result items.
`timescale 1ns / 1ps

module tmep_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_valid,
   input  tmep_pkg::byte_type       step_byte,
   input  tmep_pkg::byte_type       coord_offset,
   input  tmep_pkg::button_type     no_button,
   output tmep_pkg::push_count_type push_count,
   output tmep_pkg::rsp_type        rsp0,
   output tmep_pkg::rsp_type        rsp1
);
   import tmep_pkg::*;

   localparam logic [3:0] ST_IDLE       = 4'd0;
   localparam logic [3:0] ST_ESC        = 4'd1;
   localparam logic [3:0] ST_CSI        = 4'd2;
   localparam logic [3:0] ST_MOUSE_B    = 4'd3;
   localparam logic [3:0] ST_MOUSE_X    = 4'd4;
   localparam logic [3:0] ST_MOUSE_Y    = 4'd5;
   localparam logic [3:0] ST_OPEN_0A    = 4'd6;
   localparam logic [3:0] ST_OPEN_0B    = 4'd7;
   localparam logic [3:0] ST_OPEN_END   = 4'd8;
   localparam logic [3:0] ST_PASTE      = 4'd9;
   localparam logic [3:0] ST_CLOSE_CSI  = 4'd10;
   localparam logic [3:0] ST_CLOSE_2    = 4'd11;
   localparam logic [3:0] ST_CLOSE_0    = 4'd12;
   localparam logic [3:0] ST_CLOSE_1    = 4'd13;
   localparam logic [3:0] ST_CLOSE_END  = 4'd14;

   logic [3:0] state_ff, state_in;
   byte_type   report_b_ff, report_b_in;
   byte_type   report_x_ff, report_x_in;

   logic             bad;
   logic             in_report;
   mouse_report_type report;
   track_type        track;
   push_count_type   count;
   rsp_type          res0;
   rsp_type          res1;

   function automatic rsp_type mouse_rsp(kind_type kind, mouse_report_type rep,
                                         track_type trk);
      rsp_type r;
      r               = '0;
      r.event_kind    = kind;
      r.button_now    = rep.button;
      r.modifier_bits = rep.mods;
      r.motion_now    = rep.motion;
      r.pos_x         = rep.x;
      r.pos_y         = rep.y;
      r.press_x       = trk.press_x;
      r.press_y       = trk.press_y;
      r.press_button  = trk.press_button;
      return r;
   endfunction

   assign report.button = report_b_ff[1:0];
   assign report.mods   = report_b_ff[4:2];
   assign report.motion = report_b_ff[6:5];
   assign report.x      = coord_type'({1'b0, report_x_ff} - {1'b0, coord_offset});
   assign report.y      = coord_type'({1'b0, step_byte} - {1'b0, coord_offset});

   tmep_tracker u_tracker (
      .clock        (clock),
      .reset        (reset),
      .report_valid (step_valid && in_report),
      .report       (report),
      .no_button    (no_button),
      .track        (track)
   );

   assign in_report = (state_ff == ST_MOUSE_Y);

   always_comb begin
      state_in    = state_ff;
      report_b_in = report_b_ff;
      report_x_in = report_x_ff;
      bad         = 1'b0;
      count       = 2'd0;
      res0        = '0;
      res1        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (step_byte == ESC_CHAR) begin
               state_in = ST_ESC;
            end else begin
               res0.event_kind = EV_KEY;
               res0.key_code   = step_byte;
               count           = 2'd1;
            end
         end
         ST_ESC: begin
            if (step_byte == ESC_CHAR) state_in = ST_IDLE;
            else if (step_byte == BRACKET_CHAR) state_in = ST_CSI;
            else bad = 1'b1;
         end
         ST_CSI: begin
            if (step_byte == MOUSE_CHAR) state_in = ST_MOUSE_B;
            else if (step_byte == TWO_CHAR) state_in = ST_OPEN_0A;
            else bad = 1'b1;
         end
         ST_MOUSE_B: begin
            report_b_in = step_byte;
            state_in    = ST_MOUSE_X;
         end
         ST_MOUSE_X: begin
            report_x_in = step_byte;
            state_in    = ST_MOUSE_Y;
         end
         ST_MOUSE_Y: begin
            state_in = ST_IDLE;
            count    = track.count;
            res0     = mouse_rsp(track.kind0, report, track);
            res1     = mouse_rsp(track.kind1, report, track);
         end
         ST_OPEN_0A: begin
            if (step_byte == ZERO_CHAR) state_in = ST_OPEN_0B; else bad = 1'b1;
         end
         ST_OPEN_0B: begin
            if (step_byte == ZERO_CHAR) state_in = ST_OPEN_END; else bad = 1'b1;
         end
         ST_OPEN_END: begin
            if (step_byte == TILDE_CHAR) state_in = ST_PASTE; else bad = 1'b1;
         end
         ST_PASTE: begin
            // Pasted bytes are dropped until the closing escape arrives.
            if (step_byte == ESC_CHAR) state_in = ST_CLOSE_CSI;
         end
         ST_CLOSE_CSI: begin
            if (step_byte == BRACKET_CHAR) state_in = ST_CLOSE_2; else bad = 1'b1;
         end
         ST_CLOSE_2: begin
            if (step_byte == TWO_CHAR) state_in = ST_CLOSE_0; else bad = 1'b1;
         end
         ST_CLOSE_0: begin
            if (step_byte == ZERO_CHAR) state_in = ST_CLOSE_1; else bad = 1'b1;
         end
         ST_CLOSE_1: begin
            if (step_byte == ONE_CHAR) state_in = ST_CLOSE_END; else bad = 1'b1;
         end
         ST_CLOSE_END: begin
            if (step_byte == TILDE_CHAR) state_in = ST_IDLE; else bad = 1'b1;
         end
         default: begin
            bad = 1'b1;
         end
      endcase

      // A bad byte reports an error and leaves the parser where it was.
      if (bad) begin
         state_in        = state_ff;
         res0            = '0;
         res0.error_flag = 1'b1;
         count           = 2'd1;
      end
      if (count == 2'd1) res0.last_of_run = 1'b1;
      if (count == 2'd2) res1.last_of_run = 1'b1;
   end

   assign push_count = step_valid ? count : 2'd0;
   assign rsp0       = res0;
   assign rsp1       = res1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         report_b_ff <= '0;
         report_x_ff <= '0;
      end else if (step_valid) begin
         state_ff    <= state_in;
         report_b_ff <= report_b_in;
         report_x_ff <= report_x_in;
      end
   end

endmodule

// ===== rtl/tmep_rsp_fifo.sv =====
// Small result queue that takes up to two items per cycle and gives one.
`timescale 1ns / 1ps

module tmep_rsp_fifo (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tmep_pkg::push_count_type             push_count,
   input  tmep_pkg::rsp_type                    push_data0,
   input  tmep_pkg::rsp_type                    push_data1,
   input  logic                                 pop,
   output logic                                 head_valid,
   output tmep_pkg::rsp_type                    head_data,
   output logic [tmep_pkg::FIFO_LEVEL_W-1:0]    level
);
   import tmep_pkg::*;

   rsp_type                 mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_LEVEL_W-1:0] level_ff, level_in;
   logic [FIFO_PTR_W-1:0]   wr_ptr_next;

   assign wr_ptr_next = wr_ptr_ff + FIFO_PTR_W'(1);
   assign wr_ptr_in   = wr_ptr_ff + FIFO_PTR_W'(push_count);
   assign rd_ptr_in   = rd_ptr_ff + FIFO_PTR_W'(pop);
   assign level_in    = level_ff + FIFO_LEVEL_W'(push_count) - FIFO_LEVEL_W'(pop);

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) mem_ff[wr_ptr_ff] <= push_data0;
      if (push_count == 2'd2) mem_ff[wr_ptr_next] <= push_data1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   assign head_valid = (level_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign level      = level_ff;

endmodule

// ===== rtl/terminal_mouse_escape_parser.sv =====
// Top level of the terminal mouse escape parser: input register, parser and result queue.
`timescale 1ns / 1ps

// Channel  Direction  Carries                         Transfer when
// req_bus  in         in_byte, one terminal byte      valid && ready
// rsp_bus  out        one event, key or error result  valid && ready
// csr_*    in         register write (index, data)    csr_we
//
// A byte lands in an input register; the parser takes it when the queue has room for
// two and writes zero, one or two results into a four-entry queue, from whose head the
// results are offered on rsp_bus in order. The result port moves one result per cycle
// while rsp_bus ready is high, and a new byte can enter as the held one moves on. Reset
// is synchronous and clears the parser, tracker and queue and resets the configuration
// registers. While the queue holds more than two results a held byte stays in the input
// register and req_bus ready stays low; a stalled rsp_bus gets there quickly.

module terminal_mouse_escape_parser (
   input  logic                    clock,
   input  logic                    reset,
   tmep_req_if.sink                req_bus,
   tmep_rsp_if.source              rsp_bus,
   input  logic                    csr_we,
   input  tmep_pkg::csr_index_type csr_index,
   input  tmep_pkg::csr_data_type  csr_wdata
);
   import tmep_pkg::*;

   // Configuration registers.
   byte_type   coord_offset_ff;
   button_type no_button_ff;

   // Input register.
   logic     req_valid_ff, req_valid_in;
   byte_type req_byte_ff, req_byte_in;

   logic                    advance;
   logic                    queue_room;
   push_count_type          push_count;
   rsp_type                 rsp0;
   rsp_type                 rsp1;
   rsp_type                 head;
   logic                    head_valid;
   logic [FIFO_LEVEL_W-1:0] level;

   always_ff @(posedge clock) begin
      if (reset) begin
         coord_offset_ff <= COORD_OFFSET_RESET;
         no_button_ff    <= NO_BUTTON_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COORD_OFFSET: coord_offset_ff <= csr_wdata;
            CSR_NO_BUTTON:    no_button_ff    <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // The held byte moves on only when the queue can take the two results it
   // may produce.
   assign queue_room    = (level <= FIFO_LEVEL_W'(FIFO_DEPTH - 2));
   assign advance       = req_valid_ff && queue_room;
   assign req_bus.ready = !req_valid_ff || advance;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_byte_in  = req_byte_ff;
      if (req_bus.ready) begin
         req_valid_in = req_bus.valid;
         req_byte_in  = req_bus.in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) req_valid_ff <= 1'b0;
      else       req_valid_ff <= req_valid_in;
   end

   always_ff @(posedge clock) begin
      req_byte_ff <= req_byte_in;
   end

   tmep_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step_valid   (advance),
      .step_byte    (req_byte_ff),
      .coord_offset (coord_offset_ff),
      .no_button    (no_button_ff),
      .push_count   (push_count),
      .rsp0         (rsp0),
      .rsp1         (rsp1)
   );

   tmep_rsp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data0 (rsp0),
      .push_data1 (rsp1),
      .pop        (rsp_bus.valid && rsp_bus.ready),
      .head_valid (head_valid),
      .head_data  (head),
      .level      (level)
   );

   assign rsp_bus.valid         = head_valid;
   assign rsp_bus.event_kind    = head.event_kind;
   assign rsp_bus.error_flag    = head.error_flag;
   assign rsp_bus.key_code      = head.key_code;
   assign rsp_bus.button_now    = head.button_now;
   assign rsp_bus.modifier_bits = head.modifier_bits;
   assign rsp_bus.motion_now    = head.motion_now;
   assign rsp_bus.pos_x         = head.pos_x;
   assign rsp_bus.pos_y         = head.pos_y;
   assign rsp_bus.press_x       = head.press_x;
   assign rsp_bus.press_y       = head.press_y;
   assign rsp_bus.press_button  = head.press_button;
   assign rsp_bus.last_of_run   = head.last_of_run;

   // The queue never holds more results than it has entries.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      level <= FIFO_LEVEL_W'(FIFO_DEPTH))
      else $error("result queue level beyond its depth");

   // A byte that cannot move on stays in the input register unchanged.
   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !advance) |=> (req_valid_ff && $stable(req_byte_ff)))
      else $error("held input byte lost or changed");

   // At most two results per byte, and none without a byte.
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (push_count != 2'd3) && (advance || (push_count == 2'd0)))
      else $error("bad result push count");

endmodule

// ===== tb/tb_terminal_mouse_escape_parser.sv =====
// Self-checking testbench of the terminal mouse escape parser, driven by directed and random bytes.
`timescale 1ns / 1ps

module tb_terminal_mouse_escape_parser;
   import tmep_pkg::*;

   localparam int RESET_CYCLES    = 12;
   // This pause lets the block finish a byte that leaves no result behind it.
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 4000;

   // Parser states, in the order the escape sequences walk through them.
   typedef enum logic [3:0] {
      P_IDLE, P_ESC, P_CSI, P_BUTTON, P_COL, P_ROW,
      P_OPEN2, P_OPEN20, P_OPEN200, P_PASTE,
      P_CLOSE_ESC, P_CLOSE_CSI, P_CLOSE2, P_CLOSE20, P_CLOSE201, P_DEAD
   } parse_state_type;

   logic          clock = 1'b0;
   logic          reset;
   logic          csr_we;
   csr_index_type csr_index;
   csr_data_type  csr_wdata;

   tmep_req_if req_bus ();
   tmep_rsp_if rsp_bus ();

   terminal_mouse_escape_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Bytes waiting to be sent, and the results the accepted bytes must produce.
   byte_type terminal_bytes[$];
   rsp_type  awaited_events[$];

   // Tracker copy of the block: parser, report bytes, previous report and the
   // stored press event, plus the two registers.
   parse_state_type track_state;
   byte_type        button_byte;
   byte_type        column_byte;
   button_type      last_button;
   motion_type      last_motion;
   button_type      press_button_q;
   coord_type       press_x_q;
   coord_type       press_y_q;
   logic            dragging;
   byte_type        cfg_offset;
   button_type      cfg_no_button;

   // The stimulus generator follows the parser state of what it has queued so
   // that it can always steer the stream back to idle.
   parse_state_type gen_state;
   int              gen_count;

   int mismatch_count;
   int bytes_sent;
   int results_checked;
   int error_results;
   int settings_used;
   int kind_tally[8];

   bit sender_gaps_on;
   bit receiver_stalls_on;
   int send_gap;
   int stall_left;
   int hold_off_left;
   int quiet_cycles;

   // Parser transition for one byte. A byte that breaks the sequence leaves the
   // state where it was and is flagged as bad.
   function automatic parse_state_type next_parse(input parse_state_type st, input byte_type c,
                                                  output logic bad);
      parse_state_type nxt;
      nxt = st;
      bad = 1'b0;
      case (st)
         P_IDLE: if (c == ESC_CHAR) nxt = P_ESC;
         P_ESC: begin
            if (c == ESC_CHAR) nxt = P_IDLE;
            else if (c == BRACKET_CHAR) nxt = P_CSI;
            else bad = 1'b1;
         end
         P_CSI: begin
            if (c == MOUSE_CHAR) nxt = P_BUTTON;
            else if (c == TWO_CHAR) nxt = P_OPEN2;
            else bad = 1'b1;
         end
         P_BUTTON:    nxt = P_COL;
         P_COL:       nxt = P_ROW;
         P_ROW:       nxt = P_IDLE;
         P_OPEN2:     if (c == ZERO_CHAR) nxt = P_OPEN20; else bad = 1'b1;
         P_OPEN20:    if (c == ZERO_CHAR) nxt = P_OPEN200; else bad = 1'b1;
         P_OPEN200:   if (c == TILDE_CHAR) nxt = P_PASTE; else bad = 1'b1;
         P_PASTE:     if (c == ESC_CHAR) nxt = P_CLOSE_ESC;
         P_CLOSE_ESC: if (c == BRACKET_CHAR) nxt = P_CLOSE_CSI; else bad = 1'b1;
         P_CLOSE_CSI: if (c == TWO_CHAR) nxt = P_CLOSE2; else bad = 1'b1;
         P_CLOSE2:    if (c == ZERO_CHAR) nxt = P_CLOSE20; else bad = 1'b1;
         P_CLOSE20:   if (c == ONE_CHAR) nxt = P_CLOSE201; else bad = 1'b1;
         P_CLOSE201:  if (c == TILDE_CHAR) nxt = P_IDLE; else bad = 1'b1;
         default:     bad = 1'b1;
      endcase
      return nxt;
   endfunction

   task automatic await_event(input rsp_type r);
      awaited_events.push_back(r);
      if (r.error_flag) error_results++;
      else kind_tally[r.event_kind]++;
   endtask

   // A finished mouse report is compared with the previous one. Up to three
   // events can be found, but only the first two come out; the scroll event is
   // only added while a slot is still free.
   task automatic decode_mouse_report(input byte_type row_byte);
      kind_type   kinds[4];
      int         n;
      button_type btn;
      mods_type   mods;
      motion_type mot;
      coord_type  x;
      coord_type  y;
      logic       was_pointing;
      rsp_type    r;
      btn = button_byte[1:0];
      mods = button_byte[4:2];
      mot = button_byte[6:5];
      x = {1'b0, column_byte} - {1'b0, cfg_offset};
      y = {1'b0, row_byte} - {1'b0, cfg_offset};
      was_pointing = (last_motion == MOT_STATIC) || (last_motion == MOT_MOVING);
      n = 0;
      if (was_pointing && last_button == cfg_no_button && btn != cfg_no_button) begin
         press_button_q = btn;
         press_x_q = x;
         press_y_q = y;
         kinds[n] = EV_PRESS;
         n++;
      end
      if (last_motion == MOT_STATIC && last_button != cfg_no_button &&
          mot == MOT_MOVING && btn != cfg_no_button) begin
         dragging = 1'b1;
         kinds[n] = EV_DRAG_BEGIN;
         n++;
      end
      if (dragging) begin
         kinds[n] = EV_DRAG;
         n++;
      end else if (mot == MOT_MOVING) begin
         kinds[n] = EV_HOVER;
         n++;
      end
      if (was_pointing && last_button != cfg_no_button && mot == MOT_STATIC &&
          btn == cfg_no_button) begin
         // A release that ends a drag reports the drag end with this report.
         kinds[n] = dragging ? EV_DRAG_END : EV_RELEASE;
         dragging = 1'b0;
         n++;
      end
      if (mot == MOT_SCROLL && n < 2) begin
         kinds[n] = EV_SCROLL;
         n++;
      end
      last_button = btn;
      last_motion = mot;
      if (n > 2) n = 2;
      for (int i = 0; i < n; i++) begin
         r = '0;
         r.event_kind = kinds[i];
         r.button_now = btn;
         r.modifier_bits = mods;
         r.motion_now = mot;
         r.pos_x = x;
         r.pos_y = y;
         r.press_x = press_x_q;
         r.press_y = press_y_q;
         r.press_button = press_button_q;
         r.last_of_run = (i == n - 1);
         await_event(r);
      end
   endtask

   // Works out the results of one accepted byte.
   task automatic track_byte(input byte_type c);
      parse_state_type nxt;
      logic            bad;
      rsp_type         r;
      nxt = next_parse(track_state, c, bad);
      r = '0;
      r.last_of_run = 1'b1;
      if (bad) begin
         r.error_flag = 1'b1;
         await_event(r);
      end else begin
         case (track_state)
            P_IDLE: begin
               if (c != ESC_CHAR) begin
                  r.event_kind = EV_KEY;
                  r.key_code = c;
                  await_event(r);
               end
            end
            P_BUTTON: button_byte = c;
            P_COL:    column_byte = c;
            P_ROW:    decode_mouse_report(c);
            default:  ;
         endcase
         track_state = nxt;
      end
   endtask

   // Mostly no gap, sometimes a short one, now and then a long one.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   task automatic emit(input byte_type c);
      logic bad;
      terminal_bytes.push_back(c);
      gen_state = next_parse(gen_state, c, bad);
      gen_count++;
   endtask

   function automatic byte_type random_key();
      byte_type c;
      c = byte_type'($urandom_range(0, 254));
      if (c >= ESC_CHAR) c++;
      return c;
   endfunction

   // Button byte with the "no button" code often, all motion codes and any
   // modifiers; the unused top bit is random too.
   function automatic byte_type random_button_byte();
      button_type btn;
      motion_type mot;
      int         r;
      btn = ($urandom_range(0, 9) < 4) ? cfg_no_button : button_type'($urandom_range(0, 3));
      r = $urandom_range(0, 19);
      if (r < 8) mot = MOT_STATIC;
      else if (r < 16) mot = MOT_MOVING;
      else if (r < 19) mot = MOT_SCROLL;
      else mot = motion_type'(3);
      return {1'($urandom_range(0, 1)), mot, 3'($urandom_range(0, 7)), btn};
   endfunction

   // Coordinates lean toward the offset itself and the byte extremes.
   function automatic byte_type random_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) return cfg_offset;
      if (r == 2) return 8'h00;
      if (r == 3) return 8'hFF;
      return byte_type'($urandom_range(0, 255));
   endfunction

   // The paste brackets ESC [ 2 0 0 ~ and ESC [ 2 0 1 ~, up to a given length.
   task automatic emit_marker(input bit closing, input int count);
      byte_type marker[6];
      marker = '{ESC_CHAR, BRACKET_CHAR, TWO_CHAR, ZERO_CHAR,
                 closing ? ONE_CHAR : ZERO_CHAR, TILDE_CHAR};
      for (int i = 0; i < count; i++) emit(marker[i]);
   endtask

   // Pasted bytes are swallowed, so they do not count toward the budget.
   task automatic emit_paste_body(input int len);
      repeat (len) begin
         emit(random_key());
         gen_count--;
      end
   endtask

   task automatic send_report(input byte_type b0, input byte_type bx, input byte_type by);
      emit(ESC_CHAR);
      emit(BRACKET_CHAR);
      emit(MOUSE_CHAR);
      emit(b0);
      emit(bx);
      emit(by);
   endtask

   task automatic send_paste(input int len);
      emit_marker(1'b0, 6);
      emit_paste_body(len);
      emit_marker(1'b1, 6);
   endtask

   // A paste bracket cut short and followed by an arbitrary byte.
   task automatic send_broken();
      if ($urandom_range(0, 1)) begin
         emit_marker(1'b0, $urandom_range(1, 5));
      end else begin
         emit_marker(1'b0, 6);
         emit_paste_body($urandom_range(0, 3));
         emit_marker(1'b1, $urandom_range(1, 5));
      end
      emit(byte_type'($urandom_range(0, 255)));
   endtask

   // Feeds whatever each state needs until the parser is back in idle.
   task automatic resync();
      while (gen_state != P_IDLE) begin
         case (gen_state)
            P_ESC, P_PASTE:                emit(ESC_CHAR);
            P_CSI, P_CLOSE_CSI:            emit(TWO_CHAR);
            P_BUTTON:                      emit(random_button_byte());
            P_COL, P_ROW:                  emit(random_coord());
            P_OPEN2, P_OPEN20, P_CLOSE2:   emit(ZERO_CHAR);
            P_OPEN200, P_CLOSE201:         emit(TILDE_CHAR);
            P_CLOSE_ESC:                   emit(BRACKET_CHAR);
            P_CLOSE20:                     emit(ONE_CHAR);
            default:                       emit(ESC_CHAR);
         endcase
      end
   endtask

   // Mostly well-formed mouse reports, so that the press and drag tracking gets
   // deep; the rest is pastes, plain keys, cut-off brackets and raw noise.
   task automatic send_random(input int budget);
      int stop;
      int pick;
      stop = gen_count + budget;
      while (gen_count < stop) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) send_report(random_button_byte(), random_coord(), random_coord());
         else if (pick < 63) send_paste($urandom_range(0, 5));
         else if (pick < 78) repeat ($urandom_range(1, 3)) emit(random_key());
         else if (pick < 90) send_broken();
         else repeat ($urandom_range(1, 4)) emit(byte_type'($urandom_range(0, 255)));
         resync();
      end
   endtask

   // Directed opening, run with the reset settings (offset 32, no button 3).
   task automatic send_directed();
      // Plain keys at both byte extremes.
      emit(8'h00);
      emit(8'hFF);
      // An escape after an escape drops back to idle without a result.
      emit(ESC_CHAR);
      emit(ESC_CHAR);
      // A bad byte after the escape gives an error and the sequence then
      // carries on: a moving report with button 0 held starts a drag, with x
      // at the bottom of the range and y at the top.
      emit(ESC_CHAR);
      emit(8'h41);
      emit(BRACKET_CHAR);
      emit(MOUSE_CHAR);
      emit({1'b0, MOT_MOVING, 3'b111, 2'd0});
      emit(8'h00);
      emit(8'hFF);
      // Moving with no button keeps the drag going.
      send_report({1'b0, MOT_MOVING, 3'b000, cfg_no_button}, 8'h20, 8'h20);
      // A scroll with a button press while dragging finds press, drag and
      // scroll; the scroll does not fit and is lost.
      send_report({1'b1, MOT_SCROLL, 3'b101, 2'd1}, 8'hFF, 8'h00);
   endtask

   // Waits until everything queued has been sent and answered, then lets the
   // block finish any byte that leaves no result.
   task automatic wait_for_idle();
      do @(posedge clock);
      while (terminal_bytes.size() != 0 || req_bus.valid || awaited_events.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(input byte_type offset, input button_type no_button);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_COORD_OFFSET;
      csr_wdata <= offset;
      @(posedge clock);
      csr_index <= CSR_NO_BUTTON;
      csr_wdata <= {6'd0, no_button};
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_offset = offset;
      cfg_no_button = no_button;
      settings_used++;
   endtask

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("MISMATCH: %s", msg);
   endtask

   task automatic check_field(input string name, input logic [8:0] got, input logic [8:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                   results_checked, name, got, want));
   endtask

   task automatic check_result();
      rsp_type want;
      results_checked++;
      if (awaited_events.size() == 0) begin
         report_mismatch($sformatf("result %0d arrived with nothing expected", results_checked));
      end else begin
         want = awaited_events.pop_front();
         check_field("event_kind", rsp_bus.event_kind, want.event_kind);
         check_field("error_flag", rsp_bus.error_flag, want.error_flag);
         check_field("key_code", rsp_bus.key_code, want.key_code);
         check_field("button_now", rsp_bus.button_now, want.button_now);
         check_field("modifier_bits", rsp_bus.modifier_bits, want.modifier_bits);
         check_field("motion_now", rsp_bus.motion_now, want.motion_now);
         check_field("pos_x", rsp_bus.pos_x, want.pos_x);
         check_field("pos_y", rsp_bus.pos_y, want.pos_y);
         check_field("press_x", rsp_bus.press_x, want.press_x);
         check_field("press_y", rsp_bus.press_y, want.press_y);
         check_field("press_button", rsp_bus.press_button, want.press_button);
         check_field("last_of_run", rsp_bus.last_of_run, want.last_of_run);
      end
   endtask

   // Byte sender. An accepted byte goes through the tracker at the edge of its
   // transfer; a new byte is only offered once the previous one has gone.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            track_byte(req_bus.in_byte);
            bytes_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (terminal_bytes.size() != 0) begin
               req_bus.valid <= 1'b1;
               req_bus.in_byte <= terminal_bytes.pop_front();
               send_gap = sender_gaps_on ? idle_length() : 0;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Result receiver. The long hold-off is counted down here, so the block
   // backs up and has to stall its input while the sender keeps offering.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) check_result();
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (receiver_stalls_on && $urandom_range(0, 3) == 0) stall_left = idle_length();
         end
      end
   end

   // Watchdog: too many cycles without any transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles, %0d results still expected",
                  quiet_cycles, awaited_events.size());
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.in_byte = '0;
      rsp_bus.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_COORD_OFFSET;
      csr_wdata = '0;
      reset = 1'b1;
      quiet_cycles = 0;
      hold_off_left = 0;
      sender_gaps_on = 1'b1;
      receiver_stalls_on = 1'b1;

      track_state = P_IDLE;
      gen_state = P_IDLE;
      button_byte = '0;
      column_byte = '0;
      last_button = '0;
      last_motion = MOT_STATIC;
      press_button_q = '0;
      press_x_q = '0;
      press_y_q = '0;
      dragging = 1'b0;
      cfg_offset = COORD_OFFSET_RESET;
      cfg_no_button = NO_BUTTON_RESET;
      settings_used = 1;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      send_directed();
      send_random(150);

      // Each later phase changes both registers while the block is idle and
      // picks how the two sides pause.
      for (int phase = 1; phase <= 5; phase++) begin
         wait_for_idle();
         case (phase)
            1: begin
               // Both registers at their low end; the sender never pauses
               // while the receiver first holds off for a long stretch.
               write_settings(8'd0, 2'd0);
               sender_gaps_on = 1'b0;
               receiver_stalls_on = 1'b1;
               hold_off_left = HOLD_OFF_CYCLES;
            end
            2: begin
               write_settings(8'd255, 2'd3);
               sender_gaps_on = 1'b1;
               receiver_stalls_on = 1'b1;
            end
            3: begin
               write_settings(byte_type'($urandom_range(1, 254)), 2'd1);
               sender_gaps_on = 1'b1;
               receiver_stalls_on = 1'b0;
            end
            4: begin
               // A stretch at full rate on both sides.
               write_settings(byte_type'($urandom_range(1, 254)), 2'd2);
               sender_gaps_on = 1'b0;
               receiver_stalls_on = 1'b0;
            end
            default: begin
               write_settings(COORD_OFFSET_RESET, NO_BUTTON_RESET);
               sender_gaps_on = 1'b1;
               receiver_stalls_on = 1'b1;
            end
         endcase
         send_random(180);
      end

      wait_for_idle();

      $display("Run: %0d bytes under %0d register settings, %0d results checked, %0d mismatches.",
               bytes_sent, settings_used, results_checked, mismatch_count);
      $display("Events: key %0d, press %0d, drag begin %0d, drag %0d, hover %0d, release %0d, %s",
               kind_tally[EV_KEY], kind_tally[EV_PRESS], kind_tally[EV_DRAG_BEGIN],
               kind_tally[EV_DRAG], kind_tally[EV_HOVER], kind_tally[EV_RELEASE],
               $sformatf("drag end %0d, scroll %0d, error %0d.", kind_tally[EV_DRAG_END],
                         kind_tally[EV_SCROLL], error_results));
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tmep_pkg.sv
rtl/tmep_channels.sv
rtl/tmep_tracker.sv
rtl/tmep_parser.sv
rtl/tmep_rsp_fifo.sv
rtl/terminal_mouse_escape_parser.sv
tb/tb_terminal_mouse_escape_parser.sv
